FILE: sv/pse_pkg.sv
package pse_pkg;

    localparam int MAX_WIDTH_DEF   = 4096;
    localparam int MAX_HEIGHT_DEF  = 4096;
    localparam int BLOCK_LIMIT_DEF = 65535;

    localparam int CFG_W = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_INIT   = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;

    localparam logic [5:0] HDR_IHDR_TYPE = 6'd12;
    localparam logic [5:0] HDR_DATA_END  = 6'd28;
    localparam logic [5:0] HDR_CRC_FIRST = 6'd29;
    localparam logic [5:0] HDR_CRC_LAST  = 6'd32;
    localparam logic [5:0] HDR_LEN_FIRST = 6'd33;
    localparam logic [5:0] HDR_LEN_LAST  = 6'd36;
    localparam logic [5:0] HDR_IDAT_TYPE = 6'd37;
    localparam logic [5:0] HDR_WID_FIRST = 6'd16;
    localparam logic [5:0] HDR_WID_LAST  = 6'd19;
    localparam logic [5:0] HDR_HGT_FIRST = 6'd20;
    localparam logic [5:0] HDR_HGT_LAST  = 6'd23;
    localparam logic [5:0] HDR_LAST      = 6'd42;

    localparam logic [5:0] TRL_ADLER_LAST = 6'd3;
    localparam logic [5:0] TRL_CRC_LAST   = 6'd7;
    localparam logic [5:0] TRL_IEND_TYPE  = 6'd12;
    localparam logic [5:0] TRL_IEND_END   = 6'd15;
    localparam logic [5:0] TRL_LAST       = 6'd19;

    localparam logic [1:0] SUB_FILTER = 2'd0;
    localparam logic [1:0] SUB_RED    = 2'd1;
    localparam logic [1:0] SUB_GREEN  = 2'd2;
    localparam logic [1:0] SUB_BLUE   = 2'd3;

    localparam logic [2:0] BLK_LAST = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_RAW,
        S_TRL
    } t_state;

    typedef struct packed {
        logic [23:0] pix;
        logic        first;
        logic        row_start;
        logic        last;
    } t_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] pos);
        logic [31:0] s;
        s = v >> {2'd3 - pos, 3'd0};
        return s[7:0];
    endfunction

    function automatic logic [7:0] hdr_const(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd0:    b = 8'd137;
            6'd1:    b = 8'd80;
            6'd2:    b = 8'd78;
            6'd3:    b = 8'd71;
            6'd4:    b = 8'd13;
            6'd5:    b = 8'd10;
            6'd6:    b = 8'd26;
            6'd7:    b = 8'd10;
            6'd11:   b = 8'd13;
            6'd12:   b = 8'd73;
            6'd13:   b = 8'd72;
            6'd14:   b = 8'd68;
            6'd15:   b = 8'd82;
            6'd24:   b = 8'd8;
            6'd25:   b = 8'd2;
            6'd37:   b = 8'd73;
            6'd38:   b = 8'd68;
            6'd39:   b = 8'd65;
            6'd40:   b = 8'd84;
            6'd41:   b = 8'h78;
            6'd42:   b = 8'h01;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] trl_const(input logic [5:0] idx);
        logic [7:0] b;
        case (idx)
            6'd12:   b = 8'd73;
            6'd13:   b = 8'd69;
            6'd14:   b = 8'd78;
            6'd15:   b = 8'd68;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

FILE: sv/pse_front.sv
module pse_front #(
    parameter int MAX_WIDTH  = pse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pse_pkg::MAX_HEIGHT_DEF,
    localparam int W_W = $clog2(MAX_WIDTH + 1),
    localparam int H_W = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic [W_W-1:0]       i_eff_width,
    input  logic [H_W-1:0]       i_eff_height,
    input  logic                 i_in_valid,
    input  logic [31:0]          i_pixel_value,
    input  logic                 i_full,
    output logic                 o_push,
    output pse_pkg::t_item       o_item
);

    logic [W_W-1:0] r_col;
    logic [H_W-1:0] r_row;
    logic           end_col;
    logic           end_row;

    assign o_push  = i_in_valid && !i_full;
    assign end_col = (r_col == i_eff_width - W_W'(1));
    assign end_row = (r_row == i_eff_height - H_W'(1));

    always_comb begin
        o_item.pix       = i_pixel_value[23:0];
        o_item.first     = (r_col == '0) && (r_row == '0);
        o_item.row_start = (r_col == '0);
        o_item.last      = end_col && end_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            if (end_col) begin
                r_col <= '0;
                r_row <= end_row ? '0 : r_row + H_W'(1);
            end else begin
                r_col <= r_col + W_W'(1);
            end
        end
    end

endmodule

FILE: sv/pse_queue.sv
module pse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic           i_push,
    input  pse_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    output pse_pkg::t_item o_item,
    input  logic           i_pop
);

    localparam int DEPTH = pse_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);

    pse_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + (PTR_W+1)'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - (PTR_W+1)'(1);
            end
        end
    end

endmodule

FILE: sv/pse_len.sv
module pse_len #(
    parameter int MAX_WIDTH   = pse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = pse_pkg::MAX_HEIGHT_DEF,
    parameter int BLOCK_LIMIT = pse_pkg::BLOCK_LIMIT_DEF,
    localparam int W_W   = $clog2(MAX_WIDTH + 1),
    localparam int H_W   = $clog2(MAX_HEIGHT + 1),
    localparam int RAW_W = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [W_W-1:0]   i_eff_width,
    input  logic [H_W-1:0]   i_eff_height,
    output logic [RAW_W-1:0] o_raw_total,
    output logic [31:0]      o_zlen
);

    // The block count is a ceiling division by the block limit, done as a
    // multiplication by a scaled reciprocal that is exact for every numerator.
    localparam int NUM_W = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + BLOCK_LIMIT);
    localparam int SHIFT = NUM_W + $clog2(BLOCK_LIMIT + 1);
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(BLOCK_LIMIT) - 64'd1) / 64'(BLOCK_LIMIT);
    localparam logic [31:0] RECIP_LO = RECIP[31:0];
    localparam logic [31:0] RECIP_HI = RECIP[63:32];

    logic [W_W+1:0]     row_bytes;
    logic [W_W+H_W+1:0] product;
    logic [RAW_W-1:0]   r_raw;
    logic [NUM_W-1:0]   r_num;
    logic [NUM_W+31:0]  r_plo;
    logic [NUM_W+31:0]  r_phi;
    logic [NUM_W+63:0]  full_prod;
    logic [NUM_W-1:0]   r_q;
    logic [2:0]         r_step;

    assign row_bytes = {1'b0, i_eff_width, 1'b0} + (W_W+2)'(i_eff_width) + (W_W+2)'(1);
    assign product   = (W_W+H_W+2)'(i_eff_height) * (W_W+H_W+2)'(row_bytes);
    assign full_prod = {r_phi, 32'd0} + (NUM_W+64)'(r_plo);
    assign o_raw_total = r_raw;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_raw <= RAW_W'(product);
            r_num <= NUM_W'(product) + NUM_W'(BLOCK_LIMIT - 1);
        end
        if (r_step[0]) begin
            r_plo <= (NUM_W+32)'(r_num) * (NUM_W+32)'(RECIP_LO);
            r_phi <= (NUM_W+32)'(r_num) * (NUM_W+32)'(RECIP_HI);
        end
        if (r_step[1]) begin
            r_q <= full_prod[SHIFT +: NUM_W];
        end
        if (r_step[2]) begin
            o_zlen <= 32'(r_raw) + (32'(r_q) << 2) + 32'(r_q) + 32'd6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= {r_step[1:0], i_start};
        end
    end

endmodule

FILE: sv/pse_back.sv
module pse_back #(
    parameter int MAX_WIDTH   = pse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = pse_pkg::MAX_HEIGHT_DEF,
    parameter int BLOCK_LIMIT = pse_pkg::BLOCK_LIMIT_DEF,
    localparam int W_W   = $clog2(MAX_WIDTH + 1),
    localparam int H_W   = $clog2(MAX_HEIGHT + 1),
    localparam int RAW_W = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_q_valid,
    input  pse_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    input  logic [W_W-1:0]   i_eff_width,
    input  logic [H_W-1:0]   i_eff_height,
    input  logic [RAW_W-1:0] i_raw_total,
    input  logic [31:0]      i_zlen,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    output logic             o_end_of_image
);

    pse_pkg::t_state r_state, n_state;
    logic [5:0]      r_idx, n_idx;
    pse_pkg::t_item  r_item, n_item;
    logic [2:0]      r_bidx;
    logic            r_hdr_ok;
    logic [RAW_W-1:0] r_offset;
    logic [15:0]     r_fill;
    logic [15:0]     r_adl;
    logic [15:0]     r_adh;
    logic [31:0]     r_crc;

    logic        adv;
    logic        need_blk;
    logic        emit;
    logic [7:0]  byte_out;
    logic        fold;
    logic        crc_rst;
    logic        raw_emit;
    logic        last_flag;
    logic        eoi_flag;
    logic        fire;
    logic [RAW_W-1:0] rem;
    logic        bfinal;
    logic [15:0] len_now;
    logic [31:0] crc_in;
    logic [31:0] n_crc;
    logic [16:0] adl_sum, adh_sum;
    logic [16:0] adl_next, adh_next;
    logic [16:0] fill_inc;
    logic [1:0]  pos_m3;

    assign adv      = !o_out_valid || !i_out_stall;
    assign need_blk = (r_state == pse_pkg::S_RAW) && (r_fill == '0) && !r_hdr_ok;
    assign fire     = adv && emit;
    assign rem      = i_raw_total - r_offset;
    assign bfinal   = (32'(rem) <= 32'(BLOCK_LIMIT));
    assign len_now  = bfinal ? 16'(rem) : 16'(BLOCK_LIMIT);
    assign pos_m3   = r_idx[1:0] + 2'd3;

    always_comb begin
        emit      = 1'b0;
        byte_out  = 8'd0;
        fold      = 1'b0;
        crc_rst   = 1'b0;
        raw_emit  = 1'b0;
        last_flag = 1'b0;
        eoi_flag  = 1'b0;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                emit = 1'b0;
            end
            pse_pkg::S_HDR: begin
                emit    = 1'b1;
                crc_rst = (r_idx == pse_pkg::HDR_IHDR_TYPE) ||
                          (r_idx == pse_pkg::HDR_IDAT_TYPE);
                fold    = ((r_idx >= pse_pkg::HDR_IHDR_TYPE) &&
                           (r_idx <= pse_pkg::HDR_DATA_END)) ||
                          (r_idx >= pse_pkg::HDR_IDAT_TYPE);
                if (r_idx >= pse_pkg::HDR_WID_FIRST && r_idx <= pse_pkg::HDR_WID_LAST) begin
                    byte_out = pse_pkg::be_byte(32'(i_eff_width), r_idx[1:0]);
                end else if (r_idx >= pse_pkg::HDR_HGT_FIRST &&
                             r_idx <= pse_pkg::HDR_HGT_LAST) begin
                    byte_out = pse_pkg::be_byte(32'(i_eff_height), r_idx[1:0]);
                end else if (r_idx >= pse_pkg::HDR_CRC_FIRST &&
                             r_idx <= pse_pkg::HDR_CRC_LAST) begin
                    byte_out = pse_pkg::be_byte(~r_crc, pos_m3);
                end else if (r_idx >= pse_pkg::HDR_LEN_FIRST &&
                             r_idx <= pse_pkg::HDR_LEN_LAST) begin
                    byte_out = pse_pkg::be_byte(i_zlen, pos_m3);
                end else begin
                    byte_out = pse_pkg::hdr_const(r_idx);
                end
            end
            pse_pkg::S_RAW: begin
                emit = 1'b1;
                fold = 1'b1;
                if (need_blk) begin
                    unique case (r_bidx)
                        3'd0:    byte_out = {7'd0, bfinal};
                        3'd1:    byte_out = len_now[7:0];
                        3'd2:    byte_out = len_now[15:8];
                        3'd3:    byte_out = ~len_now[7:0];
                        default: byte_out = ~len_now[15:8];
                    endcase
                end else begin
                    raw_emit = 1'b1;
                    unique case (r_idx[1:0])
                        pse_pkg::SUB_FILTER: byte_out = 8'd0;
                        pse_pkg::SUB_RED:    byte_out = r_item.pix[23:16];
                        pse_pkg::SUB_GREEN:  byte_out = r_item.pix[15:8];
                        default:             byte_out = r_item.pix[7:0];
                    endcase
                    last_flag = (r_idx[1:0] == pse_pkg::SUB_BLUE) && !r_item.last;
                end
            end
            default: begin
                emit    = 1'b1;
                crc_rst = (r_idx == pse_pkg::TRL_IEND_TYPE);
                fold    = (r_idx <= pse_pkg::TRL_ADLER_LAST) ||
                          ((r_idx >= pse_pkg::TRL_IEND_TYPE) &&
                           (r_idx <= pse_pkg::TRL_IEND_END));
                if (r_idx <= pse_pkg::TRL_ADLER_LAST) begin
                    byte_out = pse_pkg::be_byte({r_adh, r_adl}, r_idx[1:0]);
                end else if (r_idx <= pse_pkg::TRL_CRC_LAST) begin
                    byte_out = pse_pkg::be_byte(~r_crc, r_idx[1:0]);
                end else if (r_idx > pse_pkg::TRL_IEND_END) begin
                    byte_out = pse_pkg::be_byte(~r_crc, r_idx[1:0]);
                end else begin
                    byte_out = pse_pkg::trl_const(r_idx);
                end
                last_flag = (r_idx == pse_pkg::TRL_LAST);
                eoi_flag  = (r_idx == pse_pkg::TRL_LAST);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_item  = r_item;
        o_q_pop = 1'b0;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = i_q_item.first ? pse_pkg::S_HDR : pse_pkg::S_RAW;
                    n_idx   = (i_q_item.first || i_q_item.row_start) ? 6'd0 : 6'd1;
                end
            end
            pse_pkg::S_HDR: begin
                if (fire) begin
                    if (r_idx == pse_pkg::HDR_LAST) begin
                        n_state = pse_pkg::S_RAW;
                        n_idx   = 6'd0;
                    end else begin
                        n_idx = r_idx + 6'd1;
                    end
                end
            end
            pse_pkg::S_RAW: begin
                if (fire && raw_emit) begin
                    if (r_idx[1:0] != pse_pkg::SUB_BLUE) begin
                        n_idx = r_idx + 6'd1;
                    end else if (r_item.last) begin
                        n_state = pse_pkg::S_TRL;
                        n_idx   = 6'd0;
                    end else if (i_q_valid) begin
                        o_q_pop = 1'b1;
                        n_item  = i_q_item;
                        n_state = i_q_item.first ? pse_pkg::S_HDR : pse_pkg::S_RAW;
                        n_idx   = (i_q_item.first || i_q_item.row_start) ? 6'd0 : 6'd1;
                    end else begin
                        n_state = pse_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                if (fire) begin
                    if (r_idx != pse_pkg::TRL_LAST) begin
                        n_idx = r_idx + 6'd1;
                    end else if (i_q_valid) begin
                        o_q_pop = 1'b1;
                        n_item  = i_q_item;
                        n_state = i_q_item.first ? pse_pkg::S_HDR : pse_pkg::S_RAW;
                        n_idx   = (i_q_item.first || i_q_item.row_start) ? 6'd0 : 6'd1;
                    end else begin
                        n_state = pse_pkg::S_IDLE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        crc_in   = crc_rst ? pse_pkg::CRC_INIT : r_crc;
        n_crc    = fold ? pse_pkg::crc_byte(crc_in, byte_out) : r_crc;
        adl_sum  = {1'b0, r_adl} + {9'd0, byte_out};
        adl_next = (adl_sum >= pse_pkg::ADLER_MOD) ? adl_sum - pse_pkg::ADLER_MOD : adl_sum;
        adh_sum  = {1'b0, r_adh} + adl_next;
        adh_next = (adh_sum >= pse_pkg::ADLER_MOD) ? adh_sum - pse_pkg::ADLER_MOD : adh_sum;
        fill_inc = {1'b0, r_fill} + 17'd1;
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_idx  <= n_idx;
        if (adv) begin
            o_out_byte     <= byte_out;
            o_last_of_run  <= last_flag;
            o_end_of_image <= eoi_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state     <= pse_pkg::S_IDLE;
            r_bidx      <= '0;
            r_hdr_ok    <= 1'b0;
            r_offset    <= '0;
            r_fill      <= '0;
            r_adl       <= 16'd1;
            r_adh       <= '0;
            r_crc       <= pse_pkg::CRC_INIT;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                o_out_valid <= emit;
            end
            if (fire) begin
                r_crc <= n_crc;
                if (need_blk) begin
                    if (r_bidx == pse_pkg::BLK_LAST) begin
                        r_bidx   <= '0;
                        r_hdr_ok <= 1'b1;
                    end else begin
                        r_bidx <= r_bidx + 3'd1;
                    end
                end
                if (raw_emit) begin
                    r_adl    <= adl_next[15:0];
                    r_adh    <= adh_next[15:0];
                    r_offset <= r_offset + RAW_W'(1);
                    r_fill   <= (fill_inc >= 17'(BLOCK_LIMIT)) ? 16'd0 : fill_inc[15:0];
                    r_hdr_ok <= 1'b0;
                end
                if (eoi_flag) begin
                    r_hdr_ok <= 1'b0;
                    r_offset <= '0;
                    r_fill   <= '0;
                    r_adl    <= 16'd1;
                    r_adh    <= '0;
                    r_crc    <= pse_pkg::CRC_INIT;
                end
            end
        end
    end

    a_eoi_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_image |-> o_last_of_run)
        else $error("end of image without end of run");

    a_hdr_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pse_pkg::S_HDR |-> r_item.first)
        else $error("file header for a pixel that does not open an image");

    a_blk_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bidx != '0 |-> r_state == pse_pkg::S_RAW && r_fill == '0 && !r_hdr_ok)
        else $error("stored block header interrupted");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_valid)
        else $error("pop from an empty queue");

endmodule

FILE: sv/png_stored_image_encoder_core.sv
// Throughput: one output byte per cycle unless the output stalls or the pixel queue runs empty;
// a pixel gives 3 bytes (4 at a row start), plus 5 bytes at each stored block boundary,
// 43 bytes before the first pixel and 20 after the last.
// The byte sequencer behind the four-entry pixel queue sets this rate.
// Reset is synchronous and active low; it restores the default geometry and clears the image.
// After reset or a register write the IDAT length unit recomputes the raw total and the length.
module png_stored_image_encoder_core #(
    parameter int MAX_WIDTH   = pse_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = pse_pkg::MAX_HEIGHT_DEF,
    parameter int BLOCK_LIMIT = pse_pkg::BLOCK_LIMIT_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [pse_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [31:0]               i_pixel_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [7:0]                o_out_byte,
    output logic                      o_last_of_run,
    output logic                      o_end_of_image
);

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int RAW_W = $clog2(MAX_HEIGHT * (3 * MAX_WIDTH + 1) + 1);

    logic [pse_pkg::CFG_W-1:0] r_width;
    logic [pse_pkg::CFG_W-1:0] r_height;
    logic                      r_recalc;
    logic [W_W-1:0]            eff_width;
    logic [H_W-1:0]            eff_height;
    logic                      push;
    logic                      full;
    pse_pkg::t_item            front_item;
    logic                      q_valid;
    pse_pkg::t_item            q_item;
    logic                      q_pop;
    logic [RAW_W-1:0]          raw_total;
    logic [31:0]               zlen;

    assign o_in_stall = full;

    always_comb begin
        if (r_width < pse_pkg::CFG_W'(2)) begin
            eff_width = W_W'(2);
        end else if (32'(r_width) > 32'(MAX_WIDTH)) begin
            eff_width = W_W'(MAX_WIDTH);
        end else begin
            eff_width = W_W'(r_width);
        end
        if (r_height == '0) begin
            eff_height = H_W'(1);
        end else if (32'(r_height) > 32'(MAX_HEIGHT)) begin
            eff_height = H_W'(MAX_HEIGHT);
        end else begin
            eff_height = H_W'(r_height);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= pse_pkg::RESET_WIDTH;
            r_height <= pse_pkg::RESET_HEIGHT;
            r_recalc <= 1'b1;
        end else begin
            r_recalc <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    pse_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                    pse_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                endcase
            end
        end
    end

    pse_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (i_cfg_we),
        .i_eff_width   (eff_width),
        .i_eff_height  (eff_height),
        .i_in_valid    (i_in_valid),
        .i_pixel_value (i_pixel_value),
        .i_full        (full),
        .o_push        (push),
        .o_item        (front_item)
    );

    pse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    pse_len #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .BLOCK_LIMIT (BLOCK_LIMIT)
    ) u_len (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_recalc),
        .i_eff_width  (eff_width),
        .i_eff_height (eff_height),
        .o_raw_total  (raw_total),
        .o_zlen       (zlen)
    );

    pse_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .BLOCK_LIMIT (BLOCK_LIMIT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (i_cfg_we),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .i_eff_width    (eff_width),
        .i_eff_height   (eff_height),
        .i_raw_total    (raw_total),
        .i_zlen         (zlen),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_image (o_end_of_image)
    );

endmodule

FILE: bench/testbench.sv
module testbench;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       eoi;
    } t_png_byte;

    typedef struct {
        logic [31:0] pixel;
        logic        known;
        logic [7:0]  first_byte;
    } t_row;

    localparam logic [7:0] SIG[8] = '{137, 80, 78, 71, 13, 10, 26, 10};

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [0:0]                i_cfg_index = pse_pkg::REG_FRAME_WIDTH;
    logic [pse_pkg::CFG_W-1:0] i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [31:0]               i_pixel_value = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [7:0]                o_out_byte;
    logic                      o_last_of_run;
    logic                      o_end_of_image;

    png_stored_image_encoder_core uut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [pse_pkg::CFG_W-1:0] width_reg, height_reg;
    logic [12:0]      col, row;
    logic [31:0]      raw_off;
    logic [15:0]      fill;
    logic [15:0]      sum_a, sum_b;
    logic [31:0]      crc;

    t_png_byte  png_bytes[$];
    int         errors = 0;
    int         pixels_sent = 0;
    int         images_done = 0;
    int         send_idle = 0;
    int         stall_pct = 0;

    function automatic logic [31:0] geo_width();
        if (width_reg < 2) return 2;
        if (width_reg > pse_pkg::MAX_WIDTH_DEF) return pse_pkg::MAX_WIDTH_DEF;
        return 32'(width_reg);
    endfunction

    function automatic logic [31:0] geo_height();
        if (height_reg < 1) return 1;
        if (height_reg > pse_pkg::MAX_HEIGHT_DEF) return pse_pkg::MAX_HEIGHT_DEF;
        return 32'(height_reg);
    endfunction

    function automatic logic [31:0] raw_bytes_total();
        return geo_height() * (geo_width() * 3 + 1);
    endfunction

    function automatic void clear_image();
        col = 0;
        row = 0;
        raw_off = 0;
        fill = 0;
        sum_a = 1;
        sum_b = 0;
        crc = pse_pkg::CRC_INIT;
    endfunction

    function automatic void emit(logic [7:0] b);
        png_bytes.push_back('{b, 1'b0, 1'b0});
    endfunction

    function automatic void emit_crc(logic [7:0] b);
        logic [31:0] c;
        emit(b);
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? (c >> 1) ^ pse_pkg::CRC_POLY : c >> 1;
        crc = c;
    endfunction

    function automatic void emit_word(logic [31:0] v, logic in_crc);
        for (int s = 3; s >= 0; s--) begin
            if (in_crc) emit_crc(v[s*8 +: 8]);
            else emit(v[s*8 +: 8]);
        end
    endfunction

    function automatic void start_chunk(logic [31:0] len, logic [31:0] kind);
        emit_word(len, 1'b0);
        crc = pse_pkg::CRC_INIT;
        emit_word(kind, 1'b1);
    endfunction

    function automatic void emit_raw(logic [7:0] b);
        logic [31:0] rem, len;
        if (fill == 0) begin
            rem = raw_bytes_total() - raw_off;
            len = (rem > pse_pkg::BLOCK_LIMIT_DEF) ? 32'(pse_pkg::BLOCK_LIMIT_DEF) : rem;
            emit_crc({7'd0, rem <= pse_pkg::BLOCK_LIMIT_DEF});
            emit_crc(len[7:0]);
            emit_crc(len[15:8]);
            emit_crc(~len[7:0]);
            emit_crc(~len[15:8]);
        end
        emit_crc(b);
        sum_a = 16'((32'(sum_a) + 32'(b)) % 65521);
        sum_b = 16'((32'(sum_b) + 32'(sum_a)) % 65521);
        raw_off++;
        fill = (32'(fill) + 1 >= pse_pkg::BLOCK_LIMIT_DEF) ? 16'd0 : 16'(fill + 16'd1);
    endfunction

    function automatic void encode_pixel(logic [31:0] pix);
        logic [31:0] total, blocks;
        logic        done;
        done = 1'b0;
        if (col == 0 && row == 0) begin
            total = raw_bytes_total();
            blocks = (total + pse_pkg::BLOCK_LIMIT_DEF - 1) / pse_pkg::BLOCK_LIMIT_DEF;
            foreach (SIG[i]) emit(SIG[i]);
            start_chunk(13, "IHDR");
            emit_word(geo_width(), 1'b1);
            emit_word(geo_height(), 1'b1);
            emit_crc(8'd8);
            emit_crc(8'd2);
            emit_crc(8'd0);
            emit_crc(8'd0);
            emit_crc(8'd0);
            emit_word(~crc, 1'b0);
            start_chunk(2 + blocks * 5 + total + 4, "IDAT");
            emit_crc(8'h78);
            emit_crc(8'h01);
        end
        if (col == 0) emit_raw(8'd0);
        emit_raw(pix[23:16]);
        emit_raw(pix[15:8]);
        emit_raw(pix[7:0]);
        col++;
        if (col >= geo_width()) begin
            col = 0;
            row++;
            if (row >= geo_height()) done = 1'b1;
        end
        if (done) begin
            emit_word({sum_b, sum_a}, 1'b1);
            emit_word(~crc, 1'b0);
            start_chunk(0, "IEND");
            emit_word(~crc, 1'b0);
            png_bytes[$].eoi = 1'b1;
            images_done++;
            clear_image();
        end
        png_bytes[$].last = 1'b1;
    endfunction

    task automatic send_pixel(logic [31:0] pix, logic known, logic [7:0] first_byte);
        int n0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(99) < send_idle) begin
                i_in_valid <= 1'b0;
                i_pixel_value <= $urandom;
                continue;
            end
            i_in_valid <= 1'b1;
            i_pixel_value <= pix;
            do @(posedge i_clk); while (o_in_stall);
            n0 = png_bytes.size();
            encode_pixel(pix);
            if (known) png_bytes[n0].data = first_byte;
            pixels_sent++;
            break;
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (png_bytes.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [pse_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pse_pkg::REG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        clear_image();
        repeat (40) @(posedge i_clk);
    endtask

    always @(negedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        t_png_byte e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (png_bytes.size() == 0) begin
                $error("unexpected output byte %0d", o_out_byte);
                errors++;
            end else begin
                e = png_bytes.pop_front();
                if (o_out_byte !== e.data) begin
                    $error("out_byte expected %0d actual %0d", e.data, o_out_byte);
                    errors++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run expected %0d actual %0d", e.last, o_last_of_run);
                    errors++;
                end
                if (o_end_of_image !== e.eoi) begin
                    $error("end_of_image expected %0d actual %0d", e.eoi, o_end_of_image);
                    errors++;
                end
            end
        end
    end

    t_row directed[] = '{
        '{32'h0000_0000, 1'b1, 8'd137},
        '{32'hffff_ffff, 1'b0, 8'd0},
        '{32'h00ff_0000, 1'b0, 8'd0},
        // Width 1 clamps to 2, height 0 clamps to 1: two pixels per image.
        '{32'hff00_00ff, 1'b1, 8'd137},
        '{32'h0000_ff00, 1'b0, 8'd0},
        '{32'haa55_aa55, 1'b1, 8'd137},
        '{32'h55aa_55aa, 1'b0, 8'd0},
        '{32'hffff_ffff, 1'b1, 8'd137},
        '{32'hffff_ffff, 1'b0, 8'd0},
        // Three by two image.
        '{32'h1234_5678, 1'b1, 8'd137},
        '{32'h0000_0001, 1'b0, 8'd0},
        '{32'h0080_8080, 1'b0, 8'd0},
        '{32'h00ff_ffff, 1'b0, 8'd0},
        '{32'h0100_0000, 1'b0, 8'd0},
        '{32'h7f7f_7f7f, 1'b0, 8'd0},
        // Oversized geometry clamps to the maximum; the image is abandoned.
        '{32'hdead_beef, 1'b1, 8'd137},
        '{32'hcafe_f00d, 1'b0, 8'd0}
    };

    initial begin
        #200_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        width_reg = pse_pkg::RESET_WIDTH;
        height_reg = pse_pkg::RESET_HEIGHT;
        clear_image();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (40) @(posedge i_clk);

        foreach (directed[i]) begin
            if (i == 3) begin
                wait_idle();
                write_reg(pse_pkg::REG_FRAME_WIDTH, 13'd1);
                write_reg(pse_pkg::REG_FRAME_HEIGHT, 13'd0);
            end else if (i == 9) begin
                wait_idle();
                write_reg(pse_pkg::REG_FRAME_WIDTH, 13'd3);
                write_reg(pse_pkg::REG_FRAME_HEIGHT, 13'd2);
            end else if (i == 15) begin
                wait_idle();
                write_reg(pse_pkg::REG_FRAME_WIDTH, 13'd8191);
                write_reg(pse_pkg::REG_FRAME_HEIGHT, 13'd8191);
            end
            send_pixel(directed[i].pixel, directed[i].known, directed[i].first_byte);
        end
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle = 0;  stall_pct = 0;  end
                1: begin send_idle = 80; stall_pct = 0;  end
                2: begin send_idle = 0;  stall_pct = 80; end
                default: begin send_idle = 21; stall_pct = 21; end
            endcase
            for (int k = 0; k < 4; k++) begin
                wait_idle();
                if ($urandom_range(1)) begin
                    write_reg(pse_pkg::REG_FRAME_HEIGHT, pse_pkg::CFG_W'($urandom_range(4)));
                    write_reg(pse_pkg::REG_FRAME_WIDTH, pse_pkg::CFG_W'($urandom_range(6)));
                end else begin
                    write_reg(pse_pkg::REG_FRAME_WIDTH, pse_pkg::CFG_W'($urandom_range(6)));
                    write_reg(pse_pkg::REG_FRAME_HEIGHT, pse_pkg::CFG_W'($urandom_range(4)));
                end
                repeat ($urandom_range(20, 30)) begin
                    send_pixel($urandom, 1'b0, 8'd0);
                end
            end
        end
        wait_idle();
        stall_pct = 0;

        $display("Sent %0d pixels and predicted %0d complete images, including",
                 pixels_sent, images_done);
        $display("clamped geometry, abandoned images and idle and stall phases.");
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

FILE: png_stored_image_encoder_core.f
sv/pse_pkg.sv
sv/pse_front.sv
sv/pse_queue.sv
sv/pse_len.sv
sv/pse_back.sv
sv/png_stored_image_encoder_core.sv
bench/testbench.sv
